// File: hdl/json_string_unescape_decoder_core_defines.svh
// Assertion macros used by the checker file.
`ifndef JSON_STRING_UNESCAPE_DECODER_CORE_DEFINES_SVH
`define JSON_STRING_UNESCAPE_DECODER_CORE_DEFINES_SVH

// Property checked only while out of reset
`define JSUD_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Property that also covers the reset cycles
`define JSUD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/jsud_pkg.sv
package jsud_pkg;

  // Input word: one raw byte of the string body, or the end marker
  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_input;
  } in_word_t;

  // Result word
  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_byte;
    logic       last;
    logic [2:0] status;
  } out_word_t;

  // Up to four result words caused by one input word
  typedef struct packed {
    logic [2:0]           cnt;
    out_word_t [3:0]      word;
  } res_bundle_t;

  // Status codes
  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_STR_END     = 3'd1;
  localparam logic [2:0] ST_UNEXP_END   = 3'd2;
  localparam logic [2:0] ST_BAD_HEX     = 3'd3;
  localparam logic [2:0] ST_MISSING_LOW = 3'd4;
  localparam logic [2:0] ST_BAD_LOW     = 3'd5;
  localparam logic [2:0] ST_LONE_LOW    = 3'd6;

  // Parser modes
  typedef enum logic [6:0] {
    M_PLAIN   = 7'b0000001,
    M_ESC     = 7'b0000010,
    M_UHEX    = 7'b0000100,
    M_XHEX    = 7'b0001000,
    M_HIGH_BS = 7'b0010000,
    M_HIGH_U  = 7'b0100000,
    M_LOWHEX  = 7'b1000000
  } mode_t;

  // Characters of interest
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_U     = 8'h75;
  localparam logic [7:0] CH_X     = 8'h78;

  // Surrogate prefixes (bits 15:10 of the code unit)
  localparam logic [5:0] SURR_HIGH = 6'b110110;
  localparam logic [5:0] SURR_LOW  = 6'b110111;

  // Bad-surrogate policy bits
  localparam int POL_REPLACE_BIT = 1;
  localparam int POL_DROP_BIT    = 0;

  // U+FFFD in UTF-8
  localparam logic [7:0] REPL_B0 = 8'hEF;
  localparam logic [7:0] REPL_B1 = 8'hBF;
  localparam logic [7:0] REPL_B2 = 8'hBD;

endpackage

// File: hdl/jsud_decode.sv
module jsud_decode (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 fire,
  input  jsud_pkg::in_word_t   in_word,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_policy,
  output jsud_pkg::res_bundle_t res
);
  import jsud_pkg::*;

  typedef struct packed {
    mode_t      mode;
    logic       v;
    logic [7:0] b;
  } esc_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  typedef struct packed {
    logic [2:0]      cnt;
    logic [3:0][7:0] b;
  } enc_t;

  // Escape letter after a backslash
  function automatic esc_t esc_decode(input logic [7:0] c);
    esc_t e;
    e.mode = M_PLAIN;
    e.v    = 1'b1;
    e.b    = c;
    case (c)
      CH_QUOTE, CH_BSL, CH_SLASH: e.b = c;
      CH_B: e.b = 8'h08;
      CH_F: e.b = 8'h0C;
      CH_N: e.b = 8'h0A;
      CH_R: e.b = 8'h0D;
      CH_T: e.b = 8'h09;
      CH_U: begin
        e.v    = 1'b0;
        e.mode = M_UHEX;
      end
      CH_X: begin
        e.v    = 1'b0;
        e.mode = M_XHEX;
      end
      default: e.v = 1'b0;
    endcase
    return e;
  endfunction

  // Hex digit value
  function automatic hex_t hex_digit(input logic [7:0] c);
    hex_t h;
    h.ok  = 1'b0;
    h.val = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.ok  = 1'b1;
      h.val = c[3:0];
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      h.ok  = 1'b1;
      h.val = c[3:0] + 4'd9;
    end
    return h;
  endfunction

  // UTF-8 encoder, 1 to 4 bytes
  function automatic enc_t utf8_enc(input logic [20:0] cp);
    enc_t e;
    e = '0;
    if (cp <= 21'h7F) begin
      e.cnt  = 3'd1;
      e.b[0] = cp[7:0];
    end else if (cp <= 21'h7FF) begin
      e.cnt  = 3'd2;
      e.b[0] = {3'b110, cp[10:6]};
      e.b[1] = {2'b10, cp[5:0]};
    end else if (cp <= 21'hFFFF) begin
      e.cnt  = 3'd3;
      e.b[0] = {4'b1110, cp[15:12]};
      e.b[1] = {2'b10, cp[11:6]};
      e.b[2] = {2'b10, cp[5:0]};
    end else begin
      e.cnt  = 3'd4;
      e.b[0] = {5'b11110, cp[20:18]};
      e.b[1] = {2'b10, cp[17:12]};
      e.b[2] = {2'b10, cp[11:6]};
      e.b[3] = {2'b10, cp[5:0]};
    end
    return e;
  endfunction

  mode_t       mode_r, mode_nxt;
  logic [15:0] acc_r, acc_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic [9:0]  high_r, high_nxt;
  logic [1:0]  pol_r;

  logic        pre;      // U+FFFD goes out ahead of the tail word
  logic        use_enc;
  logic [20:0] cp;
  logic        t_v;
  logic [7:0]  t_b;
  logic        t_has;
  logic [2:0]  t_st;
  esc_t        esc;
  hex_t        dig;
  logic [15:0] acc_sh;
  logic [2:0]  cnt_inc;
  enc_t        enc;
  logic [2:0]  n;
  logic        pol_rep;
  logic        pol_drop;
  logic [7:0]  c;

  assign c        = in_word.in_byte;
  assign pol_rep  = pol_r[POL_REPLACE_BIT];
  assign pol_drop = pol_r[POL_DROP_BIT];

  // Next state and up to one tail word
  always_comb begin
    mode_nxt = mode_r;
    acc_nxt  = acc_r;
    cnt_nxt  = cnt_r;
    high_nxt = high_r;
    pre      = 1'b0;
    use_enc  = 1'b0;
    cp       = '0;
    t_v      = 1'b0;
    t_b      = 8'd0;
    t_has    = 1'b0;
    t_st     = ST_OK;
    esc      = esc_decode(c);
    dig      = hex_digit(c);
    acc_sh   = {acc_r[11:0], dig.val};
    cnt_inc  = cnt_r + 3'd1;

    if (in_word.end_of_input) begin
      // stream end; after a high surrogate the policy acts first
      t_v  = 1'b1;
      t_st = ST_UNEXP_END;
      if (mode_r == M_HIGH_BS || mode_r == M_HIGH_U) begin
        if (pol_rep) pre = 1'b1;
        else if (!pol_drop) t_st = ST_MISSING_LOW;
      end
      mode_nxt = M_PLAIN;
      acc_nxt  = '0;
      cnt_nxt  = '0;
    end else begin
      case (mode_r)
        M_ESC: begin
          mode_nxt = esc.mode;
          acc_nxt  = '0;
          cnt_nxt  = '0;
          t_v      = esc.v;
          t_b      = esc.b;
          t_has    = esc.v;
        end
        M_UHEX, M_LOWHEX, M_XHEX: begin
          if (!dig.ok) begin
            t_v      = 1'b1;
            t_st     = ST_BAD_HEX;
            mode_nxt = M_PLAIN;
            acc_nxt  = '0;
            cnt_nxt  = '0;
          end else if (cnt_inc < ((mode_r == M_XHEX) ? 3'd2 : 3'd4)) begin
            acc_nxt = acc_sh;
            cnt_nxt = cnt_inc;
          end else begin
            acc_nxt  = '0;
            cnt_nxt  = '0;
            mode_nxt = M_PLAIN;
            if (mode_r == M_XHEX) begin
              t_v   = 1'b1;
              t_b   = acc_sh[7:0];
              t_has = 1'b1;
            end else if (mode_r == M_UHEX) begin
              if (acc_sh[15:10] == SURR_HIGH) begin
                high_nxt = acc_sh[9:0];
                mode_nxt = M_HIGH_BS;
              end else if (acc_sh[15:10] == SURR_LOW) begin
                // lone low surrogate
                if (pol_rep) pre = 1'b1;
                else if (!pol_drop) begin
                  t_v  = 1'b1;
                  t_st = ST_LONE_LOW;
                end
              end else begin
                use_enc = 1'b1;
                cp      = {5'd0, acc_sh};
              end
            end else begin
              if (acc_sh[15:10] == SURR_LOW) begin
                use_enc = 1'b1;
                cp      = 21'h10000 + {1'b0, high_r, acc_sh[9:0]};
              end else if (pol_rep) pre = 1'b1;
              else if (!pol_drop) begin
                t_v  = 1'b1;
                t_st = ST_BAD_LOW;
              end
            end
          end
        end
        M_HIGH_BS: begin
          if (c == CH_BSL) begin
            mode_nxt = M_HIGH_U;
          end else if (!pol_rep && !pol_drop) begin
            t_v      = 1'b1;
            t_st     = ST_MISSING_LOW;
            mode_nxt = M_PLAIN;
            acc_nxt  = '0;
            cnt_nxt  = '0;
          end else begin
            // missing low, then the byte is taken as plain
            pre      = pol_rep;
            mode_nxt = M_PLAIN;
            t_v      = 1'b1;
            if (c == CH_QUOTE) begin
              t_st    = ST_STR_END;
              acc_nxt = '0;
              cnt_nxt = '0;
            end else begin
              t_b   = c;
              t_has = 1'b1;
            end
          end
        end
        M_HIGH_U: begin
          if (c == CH_U) begin
            mode_nxt = M_LOWHEX;
            acc_nxt  = '0;
            cnt_nxt  = '0;
          end else if (!pol_rep && !pol_drop) begin
            t_v      = 1'b1;
            t_st     = ST_MISSING_LOW;
            mode_nxt = M_PLAIN;
            acc_nxt  = '0;
            cnt_nxt  = '0;
          end else begin
            // missing low, then the byte is taken as an escape letter
            pre      = pol_rep;
            mode_nxt = esc.mode;
            acc_nxt  = '0;
            cnt_nxt  = '0;
            t_v      = esc.v;
            t_b      = esc.b;
            t_has    = esc.v;
          end
        end
        default: begin
          // plain mode, and any unused mode code
          mode_nxt = (c == CH_BSL) ? M_ESC : M_PLAIN;
          if (c == CH_QUOTE) begin
            t_v     = 1'b1;
            t_st    = ST_STR_END;
            acc_nxt = '0;
            cnt_nxt = '0;
          end else if (c != CH_BSL) begin
            t_v   = 1'b1;
            t_b   = c;
            t_has = 1'b1;
          end
        end
      endcase
    end
  end

  assign enc = utf8_enc(cp);

  // Pack the result words and mark the last one
  always_comb begin
    res.word = '0;
    n        = 3'd0;
    if (pre) begin
      res.word[0].out_byte = REPL_B0;
      res.word[0].has_byte = 1'b1;
      res.word[1].out_byte = REPL_B1;
      res.word[1].has_byte = 1'b1;
      res.word[2].out_byte = REPL_B2;
      res.word[2].has_byte = 1'b1;
      res.word[3].out_byte = t_b;
      res.word[3].has_byte = t_has;
      res.word[3].status   = t_st;
      n = t_v ? 3'd4 : 3'd3;
    end else if (use_enc) begin
      for (int i = 0; i < 4; i++) begin
        res.word[i].out_byte = enc.b[i];
        res.word[i].has_byte = 1'b1;
      end
      n = enc.cnt;
    end else if (t_v) begin
      res.word[0].out_byte = t_b;
      res.word[0].has_byte = t_has;
      res.word[0].status   = t_st;
      n = 3'd1;
    end
    for (int i = 0; i < 4; i++) begin
      if (n != 3'd0 && 3'(i) == n - 3'd1) res.word[i].last = 1'b1;
    end
    res.cnt = n;
  end

  // Parser state and policy register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_PLAIN;
      acc_r  <= '0;
      cnt_r  <= '0;
      high_r <= '0;
      pol_r  <= '0;
    end else begin
      if (fire) begin
        mode_r <= mode_nxt;
        acc_r  <= acc_nxt;
        cnt_r  <= cnt_nxt;
        high_r <= high_nxt;
      end
      if (cfg_we) pol_r <= cfg_policy;
    end
  end

endmodule

// File: hdl/jsud_fifo.sv
module jsud_fifo #(
  parameter int DEPTH = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  jsud_pkg::res_bundle_t push_bundle,
  input  logic                  pop,
  output jsud_pkg::out_word_t   head,
  output logic                  not_empty,
  output logic                  room
);
  import jsud_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int MAX_PUSH = 4;

  out_word_t         mem [DEPTH];
  logic [PW-1:0]     wr_r, rd_r;
  logic [CW-1:0]     count_r, count_nxt;
  logic [2:0]        push_n;

  assign push_n    = push ? push_bundle.cnt : 3'd0;
  assign head      = mem[rd_r];
  assign not_empty = (count_r != '0);
  // room for a full burst of result words
  assign room      = (count_r <= CW'(DEPTH - MAX_PUSH));
  assign count_nxt = count_r + CW'(push_n) - CW'(pop);

  // Burst write of up to four words
  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_PUSH; i++) begin
      if (3'(i) < push_n) mem[wr_r + PW'(i)] <= push_bundle.word[i];
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r    <= '0;
      rd_r    <= '0;
      count_r <= '0;
    end else begin
      wr_r    <= wr_r + PW'(push_n);
      if (pop) rd_r <= rd_r + PW'(1);
      count_r <= count_nxt;
    end
  end

endmodule

// File: hdl/json_string_unescape_decoder_core.sv
// Channel | Direction | Handshake            | Word
// in_     | input     | in_valid / in_stall  | in_data   (in_byte, end_of_input)
// out_    | output    | out_valid / out_stall| out_data  (out_byte, has_byte, last, status)
// cfg_    | input     | cfg_valid / cfg_ready| cfg_data  (invalid_policy)
//
// One input word per cycle while in_stall is low; each is decoded once it sits in the
// input register and the queue has room, and gives 0 to 4 result words. The result
// queue drains one word per cycle while out_stall is low, so the rate is one input word
// per cycle as long as each gives at most one result; once the queue holds more than
// FIFO_DEPTH-4 words, input is held back until it has room for 4.
// Synchronous active-low reset clears the parser to plain mode and empties the queue.
// out_stall only backs up the queue; in_stall rises when the input register holds a word and the queue lacks room.
module json_string_unescape_decoder_core #(
  parameter int FIFO_DEPTH = 8   // result queue, power of two, 4 to 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  jsud_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output jsud_pkg::out_word_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_data
);
  import jsud_pkg::*;

  in_word_t    in_word_r;
  logic        in_vld_r;
  logic        room;
  logic        fire;
  res_bundle_t res;

  assign fire      = in_vld_r && room;
  assign in_stall  = in_vld_r && !room;
  assign cfg_ready = 1'b1;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) in_word_r <= in_data;
  end

  jsud_decode u_decode (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (fire),
    .in_word    (in_word_r),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_policy (cfg_data),
    .res        (res)
  );

  jsud_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (fire),
    .push_bundle (res),
    .pop         (out_valid && !out_stall),
    .head        (out_data),
    .not_empty   (out_valid),
    .room        (room)
  );

endmodule

// File: hdl/jsud_checker.sv
`include "json_string_unescape_decoder_core_defines.svh"

module jsud_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input jsud_pkg::out_word_t out_data
);
  import jsud_pkg::*;

  // stalled result word holds
  `JSUD_ASSERT(a_out_hold, clk, rst_n, (out_valid && out_stall |=> out_valid && $stable(out_data)), "stalled out word changed")

  // reset empties the queue and the input register
  `JSUD_ASSERT_ALWAYS(a_rst_clear, clk, (!rst_n |=> !out_valid && !in_stall), "not clear after reset")

  // a word without a byte ends its input word's results
  `JSUD_ASSERT(a_end_last, clk, rst_n, (out_valid && !out_data.has_byte |-> out_data.last), "byteless word not last")

  // byte words carry ok status, the others do not
  `JSUD_ASSERT(a_status, clk, rst_n, (out_valid |-> (out_data.has_byte == (out_data.status == ST_OK))), "status and has_byte disagree")

endmodule

bind json_string_unescape_decoder_core jsud_checker u_jsud_checker (.*);
